// ===== rtl/btu_pkg.sv =====
package btu_pkg;

   // Command codes
   typedef enum logic [1:0] {
      CMD_SINE   = 2'd0,
      CMD_COSINE = 2'd1,
      CMD_ATAN   = 2'd2
   } cmd_type;

   // How the octant angle of an arctangent item is found
   typedef enum logic [1:0] {
      PHI_NONE   = 2'd0,   // no angle: sine, cosine, origin, unused command
      PHI_ZERO   = 2'd1,   // point on an axis
      PHI_EIGHTH = 2'd2,   // point on a diagonal
      PHI_CORDIC = 2'd3    // iterate
   } phi_mode_type;

   localparam int CORDIC_STEPS = 24;
   localparam int COORD_W      = 32;
   localparam int COORD_SHIFT  = 28;
   localparam int CW           = 62;   // CORDIC x/y width, holds 1.65*sqrt(2)*2^59
   localparam int ZW           = 33;   // angle accumulator width
   localparam int ATAN_W       = 30;
   localparam int TRIG_W       = 11;
   localparam int ANGLE_W      = 8;
   localparam int FRAC_BITS    = 24;

   localparam logic [ATAN_W-1:0] EIGHTH_TURN  = 30'h2000_0000;
   localparam logic [ATAN_W:0]   QUARTER_TURN = 31'h4000_0000;
   localparam logic [ATAN_W+1:0] HALF_TURN    = 32'h8000_0000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // trunc(512*sin(k*pi/128)), k = 0..64
   localparam logic [9:0] SINE_QUARTER [65] = '{
        10'd0,  10'd12,  10'd25,  10'd37,  10'd50,  10'd62,  10'd75,  10'd87,
       10'd99, 10'd112, 10'd124, 10'd136, 10'd148, 10'd160, 10'd172, 10'd184,
      10'd195, 10'd207, 10'd218, 10'd230, 10'd241, 10'd252, 10'd263, 10'd273,
      10'd284, 10'd294, 10'd304, 10'd314, 10'd324, 10'd334, 10'd343, 10'd353,
      10'd362, 10'd370, 10'd379, 10'd387, 10'd395, 10'd403, 10'd411, 10'd418,
      10'd425, 10'd432, 10'd439, 10'd445, 10'd451, 10'd457, 10'd462, 10'd468,
      10'd473, 10'd477, 10'd482, 10'd486, 10'd489, 10'd493, 10'd496, 10'd499,
      10'd502, 10'd504, 10'd506, 10'd508, 10'd509, 10'd510, 10'd511, 10'd511,
      10'd512
   };

   // atan(2^-i) in 2^-32 turn
   localparam logic [ATAN_W-1:0] ATAN_STEP [32] = '{
      30'h20000000, 30'h12E4051D, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
      30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2E,
      30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
      30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
      30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051, 30'h00000028,
      30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000002, 30'h00000001,
      30'h00000000, 30'h00000000
   };

   // Item handed from the front to the back through the queue
   typedef struct packed {
      phi_mode_type        mode;
      logic                swapped;
      logic                u_neg;
      logic                v_neg;
      logic [TRIG_W-1:0]   trig;
      logic [COORD_W-1:0]  a;
      logic [COORD_W-1:0]  b;
   } entry_type;

   // Side information that travels along the CORDIC stages
   typedef struct packed {
      phi_mode_type        mode;
      logic                swapped;
      logic                u_neg;
      logic                v_neg;
      logic [TRIG_W-1:0]   trig;
   } ctl_type;

   // Sine of a binary angle times 512, from the quarter-wave table
   function automatic logic [TRIG_W-1:0] sine_of(input logic [ANGLE_W-1:0] k);
      logic [1:0]  quad;
      logic [5:0]  r;
      logic [9:0]  mag;
      logic [6:0]  mirror;
      quad   = k[7:6];
      r      = k[5:0];
      mirror = 7'd64 - {1'b0, r};
      mag    = quad[0] ? SINE_QUARTER[mirror] : SINE_QUARTER[{1'b0, r}];
      return quad[1] ? -{1'b0, mag} : {1'b0, mag};
   endfunction

endpackage

// ===== rtl/btu_front.sv =====
module btu_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_cmd,
   input  logic [btu_pkg::ANGLE_W-1:0]           req_angle_in,
   input  logic signed [btu_pkg::COORD_W-1:0]    req_x_in,
   input  logic signed [btu_pkg::COORD_W-1:0]    req_y_in,
   input  logic                                  queue_full,
   output logic                                  push,
   output btu_pkg::entry_type                    push_entry
);

   logic                   front_valid_ff;
   logic                   front_valid_in;
   btu_pkg::entry_type     entry_ff;
   btu_pkg::entry_type     entry_in;
   logic                   advance;
   logic                   accept;
   logic [btu_pkg::COORD_W-1:0] ax;
   logic [btu_pkg::COORD_W-1:0] ay;
   logic                   swap;

   // Take a new item whenever the holding register is free or draining
   assign advance    = !front_valid_ff || !queue_full;
   assign accept     = start && advance;
   assign busy       = !advance;
   assign push       = front_valid_ff && !queue_full;
   assign push_entry = entry_ff;

   // Magnitudes of the negated point, larger one first
   assign ax   = req_x_in[btu_pkg::COORD_W-1] ? (~req_x_in + 1'b1) : req_x_in;
   assign ay   = req_y_in[btu_pkg::COORD_W-1] ? (~req_y_in + 1'b1) : req_y_in;
   assign swap = ay > ax;

   // Classify the item
   always_comb begin
      entry_in         = '0;
      entry_in.mode    = btu_pkg::PHI_NONE;
      entry_in.a       = swap ? ay : ax;
      entry_in.b       = swap ? ax : ay;
      entry_in.swapped = swap;
      entry_in.u_neg   = !req_x_in[btu_pkg::COORD_W-1] && (req_x_in != '0);
      entry_in.v_neg   = !req_y_in[btu_pkg::COORD_W-1] && (req_y_in != '0);
      case (req_cmd)
         btu_pkg::CMD_SINE: begin
            entry_in.trig = btu_pkg::sine_of(req_angle_in);
         end
         btu_pkg::CMD_COSINE: begin
            entry_in.trig = btu_pkg::sine_of(req_angle_in + 8'd64);
         end
         btu_pkg::CMD_ATAN: begin
            if (entry_in.a == '0) begin
               entry_in.mode = btu_pkg::PHI_NONE;
            end else if (entry_in.b == '0) begin
               entry_in.mode = btu_pkg::PHI_ZERO;
            end else if (entry_in.b == entry_in.a) begin
               entry_in.mode = btu_pkg::PHI_EIGHTH;
            end else begin
               entry_in.mode = btu_pkg::PHI_CORDIC;
            end
         end
         default: begin
            entry_in.mode = btu_pkg::PHI_NONE;
         end
      endcase
   end

   // Hold the item until the queue takes it
   always_comb begin
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== rtl/btu_queue.sv =====
module btu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  btu_pkg::entry_type    push_entry,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output btu_pkg::entry_type    head
);

   btu_pkg::entry_type                   mem_ff [btu_pkg::QUEUE_DEPTH];
   logic [btu_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff;
   logic [btu_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff;
   logic [btu_pkg::QUEUE_CNT_W-1:0]      count_ff;
   logic [btu_pkg::QUEUE_PTR_W-1:0]      wr_ptr_in;
   logic [btu_pkg::QUEUE_PTR_W-1:0]      rd_ptr_in;
   logic [btu_pkg::QUEUE_CNT_W-1:0]      count_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign full    = count_ff == btu_pkg::QUEUE_CNT_W'(btu_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff
                + btu_pkg::QUEUE_CNT_W'(do_push)
                - btu_pkg::QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/btu_back.sv =====
module btu_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  btu_pkg::entry_type                  in_entry,
   output logic                                rsp_valid,
   output logic signed [btu_pkg::TRIG_W-1:0]   rsp_trig_value,
   output logic [btu_pkg::ANGLE_W-1:0]         rsp_angle_out
);

   localparam int N = btu_pkg::CORDIC_STEPS;

   logic                              valid_ff [N];
   btu_pkg::ctl_type                  ctl_ff   [N];
   logic signed [btu_pkg::CW-1:0]     cx_ff    [N];
   logic signed [btu_pkg::CW-1:0]     cy_ff    [N];
   logic signed [btu_pkg::ZW-1:0]     z_ff     [N];

   logic                              out_valid_ff;
   logic [btu_pkg::TRIG_W-1:0]        out_trig_ff;
   logic [btu_pkg::ANGLE_W-1:0]       out_angle_ff;
   logic [btu_pkg::ANGLE_W-1:0]       out_angle_in;

   logic [btu_pkg::ATAN_W-1:0]        phi;
   logic [btu_pkg::ATAN_W:0]          oct_angle;
   logic [btu_pkg::ATAN_W+1:0]        half_angle;
   logic [btu_pkg::ANGLE_W-1:0]       units;
   btu_pkg::ctl_type                  ctl_last;
   logic signed [btu_pkg::ZW-1:0]     z_last;

   // One vectoring rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_stage
      logic                            v_prev;
      btu_pkg::ctl_type                c_prev;
      logic signed [btu_pkg::CW-1:0]   cx_prev;
      logic signed [btu_pkg::CW-1:0]   cy_prev;
      logic signed [btu_pkg::ZW-1:0]   z_prev;
      logic signed [btu_pkg::CW-1:0]   cx_in;
      logic signed [btu_pkg::CW-1:0]   cy_in;
      logic signed [btu_pkg::ZW-1:0]   z_in;
      logic signed [btu_pkg::CW-1:0]   dx;
      logic signed [btu_pkg::CW-1:0]   dy;
      logic signed [btu_pkg::ZW-1:0]   step;

      if (i == 0) begin : g_first
         // Scale the reduced point into the CORDIC format
         assign v_prev  = in_valid;
         assign c_prev  = '{mode: in_entry.mode, swapped: in_entry.swapped,
                           u_neg: in_entry.u_neg, v_neg: in_entry.v_neg,
                           trig: in_entry.trig};
         assign cx_prev = $signed({{(btu_pkg::CW - btu_pkg::COORD_W
                                     - btu_pkg::COORD_SHIFT){1'b0}},
                                   in_entry.a, {btu_pkg::COORD_SHIFT{1'b0}}});
         assign cy_prev = $signed({{(btu_pkg::CW - btu_pkg::COORD_W
                                     - btu_pkg::COORD_SHIFT){1'b0}},
                                   in_entry.b, {btu_pkg::COORD_SHIFT{1'b0}}});
         assign z_prev  = '0;
      end else begin : g_next
         assign v_prev  = valid_ff[i-1];
         assign c_prev  = ctl_ff[i-1];
         assign cx_prev = cx_ff[i-1];
         assign cy_prev = cy_ff[i-1];
         assign z_prev  = z_ff[i-1];
      end

      assign dx   = cy_prev >>> i;
      assign dy   = cx_prev >>> i;
      assign step = $signed({{(btu_pkg::ZW - btu_pkg::ATAN_W){1'b0}},
                             btu_pkg::ATAN_STEP[i]});

      // Rotate toward the horizontal axis
      always_comb begin
         if (cy_prev > 0) begin
            cx_in = cx_prev + dx;
            cy_in = cy_prev - dy;
            z_in  = z_prev + step;
         end else begin
            cx_in = cx_prev - dx;
            cy_in = cy_prev + dy;
            z_in  = z_prev - step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         ctl_ff[i] <= c_prev;
         cx_ff[i]  <= cx_in;
         cy_ff[i]  <= cy_in;
         z_ff[i]   <= z_in;
      end
   end

   assign ctl_last = ctl_ff[N-1];
   assign z_last   = z_ff[N-1];

   // Clamp the octant angle and unfold it to the full turn
   always_comb begin
      case (ctl_last.mode)
         btu_pkg::PHI_ZERO: begin
            phi = '0;
         end
         btu_pkg::PHI_EIGHTH: begin
            phi = btu_pkg::EIGHTH_TURN;
         end
         btu_pkg::PHI_CORDIC: begin
            if (z_last < 0) begin
               phi = '0;
            end else if (z_last > $signed({{(btu_pkg::ZW - btu_pkg::ATAN_W){1'b0}},
                                           btu_pkg::EIGHTH_TURN})) begin
               phi = btu_pkg::EIGHTH_TURN;
            end else begin
               phi = z_last[btu_pkg::ATAN_W-1:0];
            end
         end
         default: begin
            phi = '0;
         end
      endcase
      oct_angle  = ctl_last.swapped ? btu_pkg::QUARTER_TURN - {1'b0, phi}
                                    : {1'b0, phi};
      half_angle = ctl_last.u_neg ? btu_pkg::HALF_TURN - {1'b0, oct_angle}
                                  : {1'b0, oct_angle};
      units      = half_angle[btu_pkg::ATAN_W+1 -: btu_pkg::ANGLE_W];
      if (ctl_last.mode == btu_pkg::PHI_NONE) begin
         out_angle_in = '0;
      end else if (ctl_last.v_neg) begin
         out_angle_in = ~units + 1'b1;
      end else begin
         out_angle_in = units;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      out_trig_ff  <= ctl_last.trig;
      out_angle_ff <= out_angle_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_trig_value = $signed(out_trig_ff);
   assign rsp_angle_out  = out_angle_ff;

endmodule

// ===== rtl/binary_angle_trig_unit.sv =====
// Trig unit on 8-bit binary angles (256 steps per turn).
// Input: drive req_cmd, req_angle_in, req_x_in and req_y_in with start high;
// the item is taken at a rising edge where start is high and busy is low.
// req_cmd 0 gives sine, 1 cosine (times 512, toward zero) on rsp_trig_value;
// 2 gives the binary angle of (-x, -y) on rsp_angle_out. Unused fields are 0.
// Output: rsp_valid is high for one cycle per item with that item's result;
// results come in the order the items were taken and must be taken then.
// Path: the front holding register, the queue memory, the CORDIC stage
// registers (the first stage reads the queue head directly) and the
// unfolding output register, which drives rsp_valid and the results.
// Throughput: one item per cycle, set by the fully pipelined CORDIC back end
// that drains one queue entry every cycle; busy stays low in that flow.
// Reset: synchronous, active high; clears all valid flags and the queue,
// dropping items in flight. No configuration.
module binary_angle_trig_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_cmd,
   input  logic [btu_pkg::ANGLE_W-1:0]         req_angle_in,
   input  logic signed [btu_pkg::COORD_W-1:0]  req_x_in,
   input  logic signed [btu_pkg::COORD_W-1:0]  req_y_in,
   output logic                                rsp_valid,
   output logic signed [btu_pkg::TRIG_W-1:0]   rsp_trig_value,
   output logic [btu_pkg::ANGLE_W-1:0]         rsp_angle_out
);

   logic                 push;
   btu_pkg::entry_type   push_entry;
   logic                 queue_full;
   logic                 queue_empty;
   btu_pkg::entry_type   head;

   btu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_angle_in (req_angle_in),
      .req_x_in     (req_x_in),
      .req_y_in     (req_y_in),
      .queue_full   (queue_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   btu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (!queue_empty),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   btu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (!queue_empty),
      .in_entry       (head),
      .rsp_valid      (rsp_valid),
      .rsp_trig_value (rsp_trig_value),
      .rsp_angle_out  (rsp_angle_out)
   );

endmodule

// ===== bench/binary_angle_trig_unit_test.sv =====
module binary_angle_trig_unit_test;

   localparam logic [1:0] CMD_UNDEFINED = 2'd3;
   localparam int RANDOM_ITEMS = 1630;
   localparam int DRAIN_CYCLES = btu_pkg::CORDIC_STEPS + 8;
   localparam int REPORT_LIMIT = 10;

   // trunc(512*sin(k*pi/128)) for the first quarter turn
   localparam int SINE_QUARTER_TURN [65] = '{
        0,  12,  25,  37,  50,  62,  75,  87,  99, 112, 124, 136, 148,
      160, 172, 184, 195, 207, 218, 230, 241, 252, 263, 273, 284, 294,
      304, 314, 324, 334, 343, 353, 362, 370, 379, 387, 395, 403, 411,
      418, 425, 432, 439, 445, 451, 457, 462, 468, 473, 477, 482, 486,
      489, 493, 496, 499, 502, 504, 506, 508, 509, 510, 511, 511, 512
   };

   // atan(2^-i) counted in 2^-32 of a turn
   localparam longint ROTATION_TURNS [32] = '{
      64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001,
      64'h00000000, 64'h00000000
   };

   localparam longint TURN_EIGHTH  = 64'h2000_0000;
   localparam longint TURN_QUARTER = 64'h4000_0000;
   localparam longint TURN_HALF    = 64'h8000_0000;

   typedef struct {
      logic [1:0]                         cmd;
      logic [btu_pkg::ANGLE_W-1:0]        angle_in;
      logic signed [btu_pkg::COORD_W-1:0] x_in;
      logic signed [btu_pkg::COORD_W-1:0] y_in;
      logic signed [btu_pkg::TRIG_W-1:0]  trig_value;
      logic [btu_pkg::ANGLE_W-1:0]        angle_out;
   } trig_answer_t;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [1:0]                          req_cmd = 2'd0;
   logic [btu_pkg::ANGLE_W-1:0]         req_angle_in = '0;
   logic signed [btu_pkg::COORD_W-1:0]  req_x_in = '0;
   logic signed [btu_pkg::COORD_W-1:0]  req_y_in = '0;
   logic                                rsp_valid;
   logic signed [btu_pkg::TRIG_W-1:0]   rsp_trig_value;
   logic [btu_pkg::ANGLE_W-1:0]         rsp_angle_out;

   trig_answer_t pending_answers [$];
   int           mismatches = 0;
   int           results_checked = 0;
   int           cmd_count [4] = '{0, 0, 0, 0};

   binary_angle_trig_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_angle_in   (req_angle_in),
      .req_x_in       (req_x_in),
      .req_y_in       (req_y_in),
      .rsp_valid      (rsp_valid),
      .rsp_trig_value (rsp_trig_value),
      .rsp_angle_out  (rsp_angle_out)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Sine times 512 from the mirrored quarter-wave table
   function automatic logic signed [btu_pkg::TRIG_W-1:0] table_sine(
      input logic [btu_pkg::ANGLE_W-1:0] k);
      int mag;
      mag = k[6] ? SINE_QUARTER_TURN[64 - k[5:0]] : SINE_QUARTER_TURN[k[5:0]];
      return btu_pkg::TRIG_W'(k[7] ? -mag : mag);
   endfunction

   // Vector (a, b) onto the axis, 0 < b < a, and accumulate the turned angle
   function automatic longint octant_turns(input longint a, input longint b);
      longint cx, cy, z, dx, dy;
      cx = a <<< btu_pkg::COORD_SHIFT;
      cy = b <<< btu_pkg::COORD_SHIFT;
      z  = 0;
      for (int i = 0; i < btu_pkg::CORDIC_STEPS && i < 32; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy > 0) begin
            cx += dx;
            cy -= dy;
            z  += ROTATION_TURNS[i];
         end else begin
            cx -= dx;
            cy += dy;
            z  -= ROTATION_TURNS[i];
         end
      end
      if (z < 0) z = 0;
      if (z > TURN_EIGHTH) z = TURN_EIGHTH;
      return z;
   endfunction

   // Binary angle of (u, v), truncated toward zero and wrapped to 8 bits
   function automatic logic [btu_pkg::ANGLE_W-1:0] point_binary_angle(
      input longint u, input longint v);
      longint a, b, t, phi, theta, units;
      logic   swapped;
      a = (u < 0) ? -u : u;
      b = (v < 0) ? -v : v;
      swapped = 1'b0;
      if (a == 0 && b == 0) return '0;
      if (b > a) begin
         t = a;
         a = b;
         b = t;
         swapped = 1'b1;
      end
      // take axis and diagonal directions exactly
      if (b == 0) phi = 0;
      else if (b == a) phi = TURN_EIGHTH;
      else phi = octant_turns(a, b);
      theta = swapped ? TURN_QUARTER - phi : phi;
      if (u < 0) theta = TURN_HALF - theta;
      if (v < 0) theta = -theta;
      if (theta >= 0) units = theta >>> btu_pkg::FRAC_BITS;
      else units = -((-theta) >>> btu_pkg::FRAC_BITS);
      return units[btu_pkg::ANGLE_W-1:0];
   endfunction

   function automatic trig_answer_t predict_answer(
      input logic [1:0] cmd, input logic [btu_pkg::ANGLE_W-1:0] angle_in,
      input logic signed [btu_pkg::COORD_W-1:0] x_in,
      input logic signed [btu_pkg::COORD_W-1:0] y_in);
      trig_answer_t ans;
      ans.cmd        = cmd;
      ans.angle_in   = angle_in;
      ans.x_in       = x_in;
      ans.y_in       = y_in;
      ans.trig_value = '0;
      ans.angle_out  = '0;
      case (cmd)
         btu_pkg::CMD_SINE: begin
            ans.trig_value = table_sine(angle_in);
         end
         btu_pkg::CMD_COSINE: begin
            ans.trig_value = table_sine(angle_in + 8'd64);
         end
         btu_pkg::CMD_ATAN: begin
            ans.angle_out = point_binary_angle(-longint'(x_in), -longint'(y_in));
         end
         default: ;
      endcase
      return ans;
   endfunction

   // Present one item and hold it until the block takes it; start stays high
   task automatic send_item(input logic [1:0] cmd,
                            input logic [btu_pkg::ANGLE_W-1:0] angle_in,
                            input logic signed [btu_pkg::COORD_W-1:0] x_in,
                            input logic signed [btu_pkg::COORD_W-1:0] y_in);
      req_cmd      <= cmd;
      req_angle_in <= angle_in;
      req_x_in     <= x_in;
      req_y_in     <= y_in;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      pending_answers.push_back(predict_answer(cmd, angle_in, x_in, y_in));
      cmd_count[cmd]++;
   endtask

   // Drop start for a gap, with noise on the request fields
   task automatic hold_off(input int cycles);
      start        <= 1'b0;
      req_cmd      <= 2'($urandom);
      req_angle_in <= 8'($urandom);
      req_x_in     <= $urandom;
      req_y_in     <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic signed [btu_pkg::COORD_W-1:0] random_coord();
      logic signed [btu_pkg::COORD_W-1:0] c;
      case ($urandom_range(0, 5))
         0: c = int'($urandom_range(0, 16)) - 8;
         1: c = $signed($urandom) >>> $urandom_range(1, 30);
         2: begin
            case ($urandom_range(0, 5))
               0: c = 32'sh8000_0000;
               1: c = 32'sh7FFF_FFFF;
               2: c = 32'sh8000_0001;
               3: c = 0;
               4: c = 1;
               default: c = -1;
            endcase
         end
         default: c = $urandom;
      endcase
      return c;
   endfunction

   // Compare every strobed result with the oldest expectation
   always @(posedge clock) begin
      trig_answer_t want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: trig %0d angle %0d",
                        rsp_trig_value, rsp_angle_out);
         end else begin
            want = pending_answers.pop_front();
            results_checked++;
            if (rsp_trig_value !== want.trig_value ||
                rsp_angle_out !== want.angle_out) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"mismatch: cmd %0d angle_in %0d x %0d y %0d:",
                            " trig expected %0d got %0d,",
                            " angle expected %0d got %0d"},
                           want.cmd, want.angle_in, want.x_in, want.y_in,
                           want.trig_value, rsp_trig_value,
                           want.angle_out, rsp_angle_out);
            end
         end
      end
   end

   // Table ends and quadrant boundaries for sine and cosine
   task automatic test_table_quadrants();
      send_item(btu_pkg::CMD_SINE,   8'd0,   32'sd17, -32'sd3);
      send_item(btu_pkg::CMD_SINE,   8'd64,  0, 0);
      send_item(btu_pkg::CMD_SINE,   8'd128, 0, 0);
      send_item(btu_pkg::CMD_SINE,   8'd192, 0, 0);
      send_item(btu_pkg::CMD_SINE,   8'd255, -1, -1);
      send_item(btu_pkg::CMD_SINE,   8'd32,  0, 0);
      send_item(btu_pkg::CMD_COSINE, 8'd0,   0, 0);
      send_item(btu_pkg::CMD_COSINE, 8'd64,  0, 0);
      send_item(btu_pkg::CMD_COSINE, 8'd128, 0, 0);
      send_item(btu_pkg::CMD_COSINE, 8'd255, 32'sh7FFF_FFFF, 32'sh8000_0000);
   endtask

   // Origin, axes, diagonals and the most negative coordinate
   task automatic test_point_directions();
      send_item(btu_pkg::CMD_ATAN, 8'd255, 0, 0);
      send_item(btu_pkg::CMD_ATAN, 8'd0, -5, 0);
      send_item(btu_pkg::CMD_ATAN, 8'd0, 5, 0);
      send_item(btu_pkg::CMD_ATAN, 8'd0, 0, 5);
      send_item(btu_pkg::CMD_ATAN, 8'd0, 0, -5);
      send_item(btu_pkg::CMD_ATAN, 8'd0, -7, -7);
      send_item(btu_pkg::CMD_ATAN, 8'd0, 7, 7);
      send_item(btu_pkg::CMD_ATAN, 8'd0, 32'sh8000_0000, 32'sh8000_0000);
      send_item(btu_pkg::CMD_ATAN, 8'd0, 32'sh8000_0000, 0);
      send_item(btu_pkg::CMD_ATAN, 8'd0, 32'sh7FFF_FFFF, -1);
      send_item(btu_pkg::CMD_ATAN, 8'd0, -1, 32'sh7FFF_FFFF);
   endtask

   // Command with no operation returns zeros whatever the fields hold
   task automatic test_undefined_command();
      send_item(CMD_UNDEFINED, 8'd100, 32'sh1234_5678, -32'sd9);
      send_item(CMD_UNDEFINED, 8'd255, 32'sh8000_0000, 32'sh7FFF_FFFF);
   endtask

   // Bursts of random items separated by random gaps
   task automatic test_random_traffic();
      int sent, burst, pick, gap;
      logic [1:0] cmd;
      logic signed [btu_pkg::COORD_W-1:0] x, y;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 4) cmd = btu_pkg::CMD_SINE;
            else if (pick < 8) cmd = btu_pkg::CMD_COSINE;
            else if (pick < 19) cmd = btu_pkg::CMD_ATAN;
            else cmd = CMD_UNDEFINED;
            x = random_coord();
            case ($urandom_range(0, 7))
               0: y = x;
               1: y = -x;
               default: y = random_coord();
            endcase
            send_item(cmd, 8'($urandom), x, y);
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) hold_off(gap);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_table_quadrants();
      test_point_directions();
      test_undefined_command();
      test_random_traffic();
      start <= 1'b0;
      // wait for the pipeline to empty, then let it settle
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("items sent: %0d sine, %0d cosine, %0d point angle, %0d undefined",
               cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
      $display("results compared: %0d, mismatches: %0d", results_checked, mismatches);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("binary_angle_trig_unit verification clean");
      end else begin
         $display("binary_angle_trig_unit verification failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #400000;
      $display("binary_angle_trig_unit verification failed");
      $finish;
   end

endmodule
